/* sv/sha1_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and fixed constants of the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  typedef logic [31:0] word_t;

  // Request opcodes
  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Initial chaining values
  localparam word_t IV_0 = 32'h67452301;
  localparam word_t IV_1 = 32'hEFCDAB89;
  localparam word_t IV_2 = 32'h98BADCFE;
  localparam word_t IV_3 = 32'h10325476;
  localparam word_t IV_4 = 32'hC3D2E1F0;

  // Round constants
  localparam word_t K_0 = 32'h5A827999;
  localparam word_t K_1 = 32'h6ED9EBA1;
  localparam word_t K_2 = 32'h8F1BBCDC;
  localparam word_t K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int unsigned NUM_WORDS = 5;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  // Start request to the compression unit
  typedef struct packed {
    logic start;
  } cmp_ctrl_t;

  // Block store read port and completion from the compression unit
  typedef struct packed {
    logic       rd_en;
    logic [3:0] rd_addr;
    logic       done;
  } cmp_stat_t;

endpackage

/* sv/sha1_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_if
// Valid/ready channels of the hasher: byte requests in, digest words out.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

/* sv/sha1_cmp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_cmp
// 80-round SHA-1 compression, one round per cycle. Message words 0..15 are
// read from the block store; later words come from a 16-word schedule line.
// ----------------------------------------------------------------------------
module sha1_cmp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1_pkg::cmp_ctrl_t ctrl_i,
  input  sha1_pkg::word_t     chain_i [5],
  input  sha1_pkg::word_t     rdata_i,
  output sha1_pkg::cmp_stat_t stat_o,
  output sha1_pkg::word_t     work_o [5]
);
  import sha1_pkg::*;

  logic       running_q, running_d;
  logic       done_q, done_d;
  logic [6:0] rnd_q, rnd_d;
  word_t      work_q [5];
  word_t      win_q  [16];

  word_t sched_w, w_cur, f_val, k_val, temp;

  // Message word: from the store for the first 16 rounds, else expanded
  always_comb begin
    sched_w = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    sched_w = {sched_w[30:0], sched_w[31]};
    w_cur   = (rnd_q < 7'd16) ? rdata_i : sched_w;
  end

  // Round function and constant
  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      k_val = K_0;
    end else if (rnd_q < 7'd40) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K_1;
    end else if (rnd_q < 7'd60) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) |
              (work_q[2] & work_q[3]);
      k_val = K_2;
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K_3;
    end
    temp = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4] + k_val + w_cur;
  end

  // Round sequencing
  always_comb begin
    running_d = running_q;
    rnd_d     = rnd_q;
    done_d    = 1'b0;
    if (ctrl_i.start) begin
      running_d = 1'b1;
      rnd_d     = '0;
    end else if (running_q) begin
      rnd_d = rnd_q + 7'd1;
      if (rnd_q == LAST_ROUND) begin
        running_d = 1'b0;
        rnd_d     = '0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      rnd_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      rnd_q     <= rnd_d;
    end
  end

  // Working variables and schedule line
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      for (int i = 0; i < 5; i++) work_q[i] <= chain_i[i];
    end else if (running_q) begin
      work_q[4] <= work_q[3];
      work_q[3] <= work_q[2];
      work_q[2] <= {work_q[1][1:0], work_q[1][31:2]};
      work_q[1] <= work_q[0];
      work_q[0] <= temp;
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= w_cur;
    end
  end

  // Prefetch the store word for the next round
  always_comb begin
    stat_o.rd_en   = ctrl_i.start | (running_q & (rnd_q < 7'd15));
    stat_o.rd_addr = running_q ? (rnd_q[3:0] + 4'd1) : 4'd0;
    stat_o.done    = done_q;
  end

  assign work_o = work_q;

endmodule

/* sv/sha1_byte_stream_hasher_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_unit
// SHA-1 over a byte stream: bytes pack big-endian into a 16-word block store,
// full blocks are compressed, finish pads and emits the 160-bit digest.
//
//   port   dir  payload                              role
//   in_i   in   opcode, data_byte                    push byte / finish
//   out_o  out  digest_word, word_index, last_word   five digest words
//
// A push is taken while idle; the 64th byte of a block also starts the store
// prefetch, the 80 rounds of the compression unit and the chaining add.
// A finish writes the rest of the block one word per cycle (up to 16), runs
// one or two compressions, then hands out five words through the output
// register. Input ready is high only while idle; the output register lets
// the last word wait on out_o.ready without holding up the next push.
// Reset loads the initial chaining values and clears the byte count.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha1_in_if.sink    in_i,
  sha1_out_if.source out_o
);
  import sha1_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_GO   = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [60:0] count_q, count_d;
  word_t       chain_q [5];
  word_t       chain_d [5];
  logic [23:0] pack_q, pack_d;
  logic [3:0]  pad_addr_q, pad_addr_d;
  logic        fin_q, fin_d;
  logic        len_blk_q, len_blk_d;
  logic [2:0]  idx_q, idx_d;

  logic        ov_q, ov_d;
  word_t       odata_q, odata_d;
  logic [2:0]  oidx_q, oidx_d;
  logic        olast_q, olast_d;

  // Block store
  word_t       mem [16];
  word_t       rdata_q;
  logic        wr_en;
  logic [3:0]  wr_addr;
  word_t       wr_data;

  cmp_ctrl_t   cmp_ctrl;
  cmp_stat_t   cmp_stat;
  word_t       work [5];

  logic        in_acc;
  logic [5:0]  pos;
  word_t       fin_word;
  word_t       pad_word;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign pos        = count_q[5:0];

  // Close the partial word with the pad byte
  always_comb begin
    case (pos[1:0])
      2'd0:    fin_word = {PAD_BYTE, 24'h0};
      2'd1:    fin_word = {pack_q[23:16], PAD_BYTE, 16'h0};
      2'd2:    fin_word = {pack_q[23:8], PAD_BYTE, 8'h0};
      2'd3:    fin_word = {pack_q, PAD_BYTE};
      default: fin_word = '0;
    endcase
  end

  // Zero fill, with the bit length in the last two words of the final block
  always_comb begin
    pad_word = '0;
    if (len_blk_q && pad_addr_q == 4'd14) pad_word = count_q[60:29];
    if (len_blk_q && pad_addr_q == 4'd15) pad_word = {count_q[28:0], 3'b000};
  end

  // Control sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    chain_d    = chain_q;
    pack_d     = pack_q;
    pad_addr_d = pad_addr_q;
    fin_d      = fin_q;
    len_blk_d  = len_blk_q;
    idx_d      = idx_q;
    ov_d       = ov_q;
    odata_d    = odata_q;
    oidx_d     = oidx_q;
    olast_d    = olast_q;
    wr_en      = 1'b0;
    wr_addr    = pos[5:2];
    wr_data    = '0;
    cmp_ctrl.start = 1'b0;

    // Drop the output request once taken
    if (ov_q && out_o.ready) ov_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == OP_PUSH) begin
            count_d = count_q + 61'd1;
            case (pos[1:0])
              2'd0:    pack_d = {in_i.data_byte, 16'h0};
              2'd1:    pack_d[15:8] = in_i.data_byte;
              2'd2:    pack_d[7:0] = in_i.data_byte;
              default: begin
                wr_en   = 1'b1;
                wr_data = {pack_q, in_i.data_byte};
              end
            endcase
            if (pos == 6'd63) state_d = ST_GO;
          end else begin
            wr_en      = 1'b1;
            wr_data    = fin_word;
            fin_d      = 1'b1;
            len_blk_d  = (pos < 6'd56);
            pad_addr_d = pos[5:2] + 4'd1;
            state_d    = (pos[5:2] == 4'd15) ? ST_GO : ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr_en      = 1'b1;
        wr_addr    = pad_addr_q;
        wr_data    = pad_word;
        pad_addr_d = pad_addr_q + 4'd1;
        if (pad_addr_q == 4'd15) state_d = ST_GO;
      end
      ST_GO: begin
        cmp_ctrl.start = 1'b1;
        state_d        = ST_WAIT;
      end
      ST_WAIT: begin
        if (cmp_stat.done) begin
          for (int i = 0; i < 5; i++) chain_d[i] = chain_q[i] + work[i];
          if (!fin_q) begin
            state_d = ST_IDLE;
          end else if (!len_blk_q) begin
            len_blk_d  = 1'b1;
            pad_addr_d = '0;
            state_d    = ST_PAD;
          end else begin
            idx_d   = '0;
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          odata_d = chain_q[idx_q];
          oidx_d  = idx_q;
          olast_d = (idx_q == 3'(NUM_WORDS - 1));
          idx_d   = idx_q + 3'd1;
          if (idx_q == 3'(NUM_WORDS - 1)) begin
            // Back to the initial state for the next message
            chain_d[0] = IV_0;
            chain_d[1] = IV_1;
            chain_d[2] = IV_2;
            chain_d[3] = IV_3;
            chain_d[4] = IV_4;
            count_d    = '0;
            fin_d      = 1'b0;
            state_d    = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      chain_q[0] <= IV_0;
      chain_q[1] <= IV_1;
      chain_q[2] <= IV_2;
      chain_q[3] <= IV_3;
      chain_q[4] <= IV_4;
      pad_addr_q <= '0;
      fin_q      <= 1'b0;
      len_blk_q  <= 1'b0;
      idx_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      chain_q    <= chain_d;
      pad_addr_q <= pad_addr_d;
      fin_q      <= fin_d;
      len_blk_q  <= len_blk_d;
      idx_q      <= idx_d;
      ov_q       <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pack_q  <= pack_d;
    odata_q <= odata_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
  end

  // Block store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmp_stat.rd_en) rdata_q <= mem[cmp_stat.rd_addr];
  end

  sha1_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cmp_ctrl),
    .chain_i(chain_q),
    .rdata_i(rdata_q),
    .stat_o (cmp_stat),
    .work_o (work)
  );

  assign out_o.valid       = ov_q;
  assign out_o.digest_word = odata_q;
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = olast_q;

endmodule
